// ----- src/tmps_pkg.sv -----
package tmps_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int NUM_PAIRS   = 6;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [1:0] pidx_t;
    typedef logic [2:0] pair_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    typedef struct packed {
        coord_t pt0_x;
        coord_t pt0_y;
        coord_t pt0_z;
        coord_t pt1_x;
        coord_t pt1_y;
        coord_t pt1_z;
        coord_t pt2_x;
        coord_t pt2_y;
        coord_t pt2_z;
        coord_t pt3_x;
        coord_t pt3_y;
        coord_t pt3_z;
    } pts_t;

    typedef struct packed {
        logic  sorted_ok;
        pidx_t index_first;
        pidx_t index_second;
        pidx_t index_third;
        pidx_t index_fourth;
    } order_t;

    // one coordinate of one point
    function automatic coord_t coord(pts_t p, pidx_t idx, axis_t ax);
        coord_t c;
        c = '0;
        case (idx)
            2'd0:
            begin
                case (ax)
                    AXIS_X:  c = p.pt0_x;
                    AXIS_Y:  c = p.pt0_y;
                    default: c = p.pt0_z;
                endcase
            end
            2'd1:
            begin
                case (ax)
                    AXIS_X:  c = p.pt1_x;
                    AXIS_Y:  c = p.pt1_y;
                    default: c = p.pt1_z;
                endcase
            end
            2'd2:
            begin
                case (ax)
                    AXIS_X:  c = p.pt2_x;
                    AXIS_Y:  c = p.pt2_y;
                    default: c = p.pt2_z;
                endcase
            end
            default:
            begin
                case (ax)
                    AXIS_X:  c = p.pt3_x;
                    AXIS_Y:  c = p.pt3_y;
                    default: c = p.pt3_z;
                endcase
            end
        endcase
        return c;
    endfunction

    // pair order 01,02,03,12,13,23
    function automatic pidx_t pair_lo(pair_t k);
        pidx_t r;
        case (k)
            3'd0, 3'd1, 3'd2: r = 2'd0;
            3'd3, 3'd4:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic pidx_t pair_hi(pair_t k);
        pidx_t r;
        case (k)
            3'd0:       r = 2'd1;
            3'd1, 3'd3: r = 2'd2;
            default:    r = 2'd3;
        endcase
        return r;
    endfunction

    // the two points left over by each pair
    function automatic pidx_t rest_lo(pair_t k);
        pidx_t r;
        case (k)
            3'd0:       r = 2'd2;
            3'd1, 3'd2: r = 2'd1;
            default:    r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic pidx_t rest_hi(pair_t k);
        pidx_t r;
        case (k)
            3'd0, 3'd1: r = 2'd3;
            3'd2:       r = 2'd2;
            3'd3:       r = 2'd3;
            3'd4:       r = 2'd2;
            default:    r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

// ----- src/tmps_sq3.sv -----
// squared length of a 3-vector: squares in one stage, sum in the next
module tmps_sq3 #(
    parameter int IN_WIDTH = 17
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [2:0][IN_WIDTH-1:0]  vec,
    output logic [2*IN_WIDTH:0]       len
);

    localparam int PRODW = 2 * IN_WIDTH;
    localparam int SQW   = 2 * IN_WIDTH - 1;
    localparam int LENW  = 2 * IN_WIDTH + 1;

    logic signed [PRODW-1:0] prod [3];
    logic [SQW-1:0]          sq_reg [3];
    logic [LENW-1:0]         len_reg;
    logic [LENW-1:0]         len_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod[k] = $signed(vec[k]) * $signed(vec[k]);
        end
    end

    // a square never needs the top product bit
    assign len_next = LENW'(sq_reg[0]) + LENW'(sq_reg[1]) + LENW'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= prod[k][SQW-1:0];
            end
            len_reg <= len_next;
        end
    end

    assign len = len_reg;

endmodule

// ----- src/tetrahedron_marker_point_sorter.sv -----
// channel | dir | handshake          | payload
// pts     | in  | pts_valid/stall    | tmps_pkg::pts_t, four points x/y/z
// order   | out | order_valid/stall  | tmps_pkg::order_t, ok flag and four indices
//
// one point set per cycle while the output register is not stalled
// twelve register stages: pair lengths, longest pair, midpoint distances, cross signs
// asynchronous active-low reset clears only the stage valid bits
// a stalled full output register freezes every stage at once; pts_stall follows it

module tetrahedron_marker_point_sorter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pts_valid,
    output logic             pts_stall,
    input  tmps_pkg::pts_t   pts,
    output logic             order_valid,
    input  logic             order_stall,
    output tmps_pkg::order_t order
);

    localparam int W   = tmps_pkg::COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int LW  = 2 * DW + 1;
    localparam int MW  = W + 2;
    localparam int MLW = 2 * MW + 1;
    localparam int PW  = 2 * DW;
    localparam int XW  = PW + 1;
    localparam int NST = 12;

    logic adv;
    logic [NST-1:0] vld_reg;

    tmps_pkg::pts_t pt_reg [1:9];

    // stage 2: pair differences
    logic [2:0][DW-1:0] dif_reg  [tmps_pkg::NUM_PAIRS];
    logic [2:0][DW-1:0] dif_next [tmps_pkg::NUM_PAIRS];
    logic [LW-1:0]      plen     [tmps_pkg::NUM_PAIRS];

    // stages 5 and 6: longest pair
    tmps_pkg::pair_t win_reg  [3];
    tmps_pkg::pair_t win_next [3];
    logic [LW-1:0]   wlen_reg  [3];
    logic [LW-1:0]   wlen_next [3];
    tmps_pkg::pair_t best_reg;
    tmps_pkg::pair_t best_next;

    // stage 7 to 9: pair ends, leftover points, midpoint vectors
    tmps_pkg::pidx_t a_reg [7:9];
    tmps_pkg::pidx_t b_reg [7:9];
    tmps_pkg::pidx_t r0_reg [7:9];
    tmps_pkg::pidx_t r1_reg [7:9];
    logic [2:0][MW-1:0] m0_reg;
    logic [2:0][MW-1:0] m0_next;
    logic [2:0][MW-1:0] m1_reg;
    logic [2:0][MW-1:0] m1_next;
    logic [MLW-1:0]     mlen0;
    logic [MLW-1:0]     mlen1;

    // stage 10: third/fourth and cross product operands
    tmps_pkg::pidx_t a10_reg, b10_reg, t3_10_reg, t4_10_reg;
    tmps_pkg::pidx_t t3_next, t4_next;
    logic signed [DW-1:0] ux_reg, uy_reg, vax_reg, vay_reg, vbx_reg, vby_reg;
    logic signed [DW-1:0] ux_next, uy_next, vax_next, vay_next, vbx_next, vby_next;

    // stage 11: products
    tmps_pkg::pidx_t a11_reg, b11_reg, t3_11_reg, t4_11_reg;
    logic signed [PW-1:0] pa1_reg, pa2_reg, pb1_reg, pb2_reg;

    // stage 12: result
    logic signed [XW-1:0] da, db;
    tmps_pkg::order_t out_reg;
    tmps_pkg::order_t out_next;

    // the whole pipe moves unless the output holds an untaken result
    assign adv       = !(vld_reg[NST-1] && order_stall);
    assign pts_stall = vld_reg[NST-1] && order_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-2:0], pts_valid};
        end
    end

    always_comb
    begin
        for (int k = 0; k < tmps_pkg::NUM_PAIRS; k++)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                dif_next[k][ax] =
                    DW'(tmps_pkg::coord(pt_reg[1],
                                        tmps_pkg::pair_lo(tmps_pkg::pair_t'(k)),
                                        tmps_pkg::axis_t'(ax)))
                  - DW'(tmps_pkg::coord(pt_reg[1],
                                        tmps_pkg::pair_hi(tmps_pkg::pair_t'(k)),
                                        tmps_pkg::axis_t'(ax)));
            end
        end
    end

    for (genvar g = 0; g < tmps_pkg::NUM_PAIRS; g++)
    begin : g_pair_len
        tmps_sq3 #(
            .IN_WIDTH(DW)
        ) u_pair_len (
            .clk(clk),
            .en (adv),
            .vec(dif_reg[g]),
            .len(plen[g])
        );
    end

    // first maximum wins: the later pair of a compare only wins when strictly longer
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (plen[2*j+1] > plen[2*j])
            begin
                win_next[j]  = tmps_pkg::pair_t'(2*j+1);
                wlen_next[j] = plen[2*j+1];
            end
            else
            begin
                win_next[j]  = tmps_pkg::pair_t'(2*j);
                wlen_next[j] = plen[2*j];
            end
        end
    end

    always_comb
    begin
        logic [LW-1:0] blen;
        best_next = win_reg[0];
        blen      = wlen_reg[0];
        if (wlen_reg[1] > blen)
        begin
            best_next = win_reg[1];
            blen      = wlen_reg[1];
        end
        if (wlen_reg[2] > blen)
        begin
            best_next = win_reg[2];
        end
    end

    // a + b - 2p for both leftover points
    always_comb
    begin
        tmps_pkg::pidx_t ia, ib, ir0, ir1;
        ia  = tmps_pkg::pair_lo(best_reg);
        ib  = tmps_pkg::pair_hi(best_reg);
        ir0 = tmps_pkg::rest_lo(best_reg);
        ir1 = tmps_pkg::rest_hi(best_reg);
        for (int ax = 0; ax < 3; ax++)
        begin
            m0_next[ax] =
                MW'(tmps_pkg::coord(pt_reg[6], ia, tmps_pkg::axis_t'(ax)))
              + MW'(tmps_pkg::coord(pt_reg[6], ib, tmps_pkg::axis_t'(ax)))
              - (MW'(tmps_pkg::coord(pt_reg[6], ir0, tmps_pkg::axis_t'(ax))) <<< 1);
            m1_next[ax] =
                MW'(tmps_pkg::coord(pt_reg[6], ia, tmps_pkg::axis_t'(ax)))
              + MW'(tmps_pkg::coord(pt_reg[6], ib, tmps_pkg::axis_t'(ax)))
              - (MW'(tmps_pkg::coord(pt_reg[6], ir1, tmps_pkg::axis_t'(ax))) <<< 1);
        end
    end

    tmps_sq3 #(
        .IN_WIDTH(MW)
    ) u_mid_len0 (
        .clk(clk),
        .en (adv),
        .vec(m0_reg),
        .len(mlen0)
    );

    tmps_sq3 #(
        .IN_WIDTH(MW)
    ) u_mid_len1 (
        .clk(clk),
        .en (adv),
        .vec(m1_reg),
        .len(mlen1)
    );

    // tie on midpoint distance makes the second leftover point third
    always_comb
    begin
        if (mlen0 < mlen1)
        begin
            t3_next = r0_reg[9];
            t4_next = r1_reg[9];
        end
        else
        begin
            t3_next = r1_reg[9];
            t4_next = r0_reg[9];
        end
        ux_next  = DW'(tmps_pkg::coord(pt_reg[9], t3_next, tmps_pkg::AXIS_X))
                 - DW'(tmps_pkg::coord(pt_reg[9], t4_next, tmps_pkg::AXIS_X));
        uy_next  = DW'(tmps_pkg::coord(pt_reg[9], t3_next, tmps_pkg::AXIS_Y))
                 - DW'(tmps_pkg::coord(pt_reg[9], t4_next, tmps_pkg::AXIS_Y));
        vax_next = DW'(tmps_pkg::coord(pt_reg[9], t3_next, tmps_pkg::AXIS_X))
                 - DW'(tmps_pkg::coord(pt_reg[9], a_reg[9], tmps_pkg::AXIS_X));
        vay_next = DW'(tmps_pkg::coord(pt_reg[9], t3_next, tmps_pkg::AXIS_Y))
                 - DW'(tmps_pkg::coord(pt_reg[9], a_reg[9], tmps_pkg::AXIS_Y));
        vbx_next = DW'(tmps_pkg::coord(pt_reg[9], t3_next, tmps_pkg::AXIS_X))
                 - DW'(tmps_pkg::coord(pt_reg[9], b_reg[9], tmps_pkg::AXIS_X));
        vby_next = DW'(tmps_pkg::coord(pt_reg[9], t3_next, tmps_pkg::AXIS_Y))
                 - DW'(tmps_pkg::coord(pt_reg[9], b_reg[9], tmps_pkg::AXIS_Y));
    end

    assign da = XW'(pa1_reg) - XW'(pa2_reg);
    assign db = XW'(pb1_reg) - XW'(pb2_reg);

    always_comb
    begin
        logic sa_neg, sa_zero, sb_neg, sb_zero;
        sa_neg  = da[XW-1];
        sa_zero = (da == '0);
        sb_neg  = db[XW-1];
        sb_zero = (db == '0);
        out_next = '0;
        if (!sa_zero && !sb_zero && (sa_neg != sb_neg))
        begin
            out_next.sorted_ok = 1'b1;
            if (!sa_neg)
            begin
                out_next.index_first  = b11_reg;
                out_next.index_second = a11_reg;
            end
            else
            begin
                out_next.index_first  = a11_reg;
                out_next.index_second = b11_reg;
            end
            out_next.index_third  = t3_11_reg;
            out_next.index_fourth = t4_11_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_reg[1] <= pts;
            for (int s = 2; s <= 9; s++)
            begin
                pt_reg[s] <= pt_reg[s-1];
            end

            for (int k = 0; k < tmps_pkg::NUM_PAIRS; k++)
            begin
                dif_reg[k] <= dif_next[k];
            end

            for (int j = 0; j < 3; j++)
            begin
                win_reg[j]  <= win_next[j];
                wlen_reg[j] <= wlen_next[j];
            end
            best_reg <= best_next;

            a_reg[7]  <= tmps_pkg::pair_lo(best_reg);
            b_reg[7]  <= tmps_pkg::pair_hi(best_reg);
            r0_reg[7] <= tmps_pkg::rest_lo(best_reg);
            r1_reg[7] <= tmps_pkg::rest_hi(best_reg);
            for (int s = 8; s <= 9; s++)
            begin
                a_reg[s]  <= a_reg[s-1];
                b_reg[s]  <= b_reg[s-1];
                r0_reg[s] <= r0_reg[s-1];
                r1_reg[s] <= r1_reg[s-1];
            end
            m0_reg <= m0_next;
            m1_reg <= m1_next;

            a10_reg   <= a_reg[9];
            b10_reg   <= b_reg[9];
            t3_10_reg <= t3_next;
            t4_10_reg <= t4_next;
            ux_reg    <= ux_next;
            uy_reg    <= uy_next;
            vax_reg   <= vax_next;
            vay_reg   <= vay_next;
            vbx_reg   <= vbx_next;
            vby_reg   <= vby_next;

            a11_reg   <= a10_reg;
            b11_reg   <= b10_reg;
            t3_11_reg <= t3_10_reg;
            t4_11_reg <= t4_10_reg;
            pa1_reg   <= ux_reg * vay_reg;
            pa2_reg   <= uy_reg * vax_reg;
            pb1_reg   <= ux_reg * vby_reg;
            pb2_reg   <= uy_reg * vbx_reg;

            out_reg <= out_next;
        end
    end

    assign order_valid = vld_reg[NST-1];
    assign order       = out_reg;

    a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
        order_valid && !order.sorted_ok |->
            order.index_first == 2'd0 && order.index_second == 2'd0 &&
            order.index_third == 2'd0 && order.index_fourth == 2'd0)
        else $error("failed sort carries nonzero indices");

    a_ok_distinct : assert property (@(posedge clk) disable iff (!rst_n)
        order_valid && order.sorted_ok |->
            order.index_first != order.index_second &&
            order.index_first != order.index_third &&
            order.index_first != order.index_fourth &&
            order.index_second != order.index_third &&
            order.index_second != order.index_fourth &&
            order.index_third != order.index_fourth)
        else $error("sorted indices are not a permutation");

    a_empty_no_stall : assert property (@(posedge clk) disable iff (!rst_n)
        !order_valid |-> !pts_stall)
        else $error("input stalled while output register is empty");

    a_stall_freeze : assert property (@(posedge clk) disable iff (!rst_n)
        pts_stall |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

endmodule
